// ===== hw/rtl/bsu_pkg.sv =====
// Shared constants, codes and helper functions for the bus symbol unescaper.
package bsu_pkg;

  // History ring geometry
  localparam int unsigned HIST_DEPTH = 32;
  localparam int unsigned HIST_IDX_W = $clog2(HIST_DEPTH);

  // CRC-8 generator polynomial (MSB first)
  localparam logic [7:0] CRC_POLY = 8'h9B;

  // Request actions
  localparam logic [1:0] ACT_RECEIVE = 2'd0;
  localparam logic [1:0] ACT_DRAIN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_ESCAPE  = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_SYNC    = 3'd2;
  localparam logic [2:0] KIND_HISTORY = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;
  localparam logic [2:0] KIND_CLEARED = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_CODE   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_CODE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] SYNC_CODE_RST   = 8'd170;
  localparam logic [7:0] ESCAPE_CODE_RST = 8'd169;

  // Table term of the CRC update: value shifted through eight polynomial steps
  function automatic logic [7:0] crc_table(input logic [7:0] val);
    logic [7:0] c;
    c = val;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Ring pointer increment with wrap at the history depth
  function automatic logic [HIST_IDX_W-1:0] ring_next(input logic [HIST_IDX_W-1:0] idx);
    logic [HIST_IDX_W-1:0] r;
    if (idx == HIST_IDX_W'(HIST_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bus_symbol_unescape_history.sv =====
// Bus symbol unescaper with running CRC-8 and a drainable ring history.
// Each request carries an action: receive a raw bus byte, drain the history or clear the
// CRC. A receive or clear request gives one result; a receive updates the CRC (table
// term of the old CRC xor the byte), resolves escape pairs and stores decoded data
// symbols into a 32-entry history RAM that overwrites its oldest entry when full (at
// most 31 held). A drain on an empty history gives one "empty" result; otherwise it
// gives one history result per stored symbol, the last one marked, each symbol read
// from the history RAM through its registered read port before it is presented.
// Results sit in an output register; the next request is taken in the cycle the
// waiting result is accepted, so a stalled receiver stalls the request side.
// Configuration writes (sync code, escape code) are taken in any cycle; the history RAM
// has no reset and needs no clearing pass.
module bus_symbol_unescape_history (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_raw_symbol,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_symbol_out,
  output logic [7:0] out_crc_now,
  output logic       out_last,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int unsigned IW = bsu_pkg::HIST_IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_OUT} state_t;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    kind_r, kind_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [7:0]    crc_out_r, crc_out_nxt;
  logic          last_r, last_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [IW-1:0] oldest_r, oldest_nxt;
  logic [IW-1:0] next_r, next_nxt;
  logic [7:0]    sync_code_r, escape_code_r;

  // history RAM
  logic [7:0]    hist_mem [bsu_pkg::HIST_DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_we, mem_re;
  logic [7:0]    mem_wdata;

  logic          out_free, in_fire;
  logic [7:0]    crc_rx;
  logic [IW-1:0] push_next;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_symbol_out = sym_r;
  assign out_crc_now    = crc_out_r;
  assign out_last       = last_r;

  assign crc_rx    = bsu_pkg::crc_table(crc_r) ^ in_raw_symbol;
  assign push_next = bsu_pkg::ring_next(next_r);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    sym_nxt       = sym_r;
    crc_out_nxt   = crc_out_r;
    last_nxt      = last_r;
    esc_nxt       = esc_r;
    crc_nxt       = crc_r;
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = in_raw_symbol;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            bsu_pkg::ACT_RECEIVE: begin
              crc_nxt       = crc_rx;
              out_valid_nxt = 1'b1;
              crc_out_nxt   = crc_rx;
              last_nxt      = 1'b1;
              sym_nxt       = '0;
              if (esc_r) begin
                esc_nxt = 1'b0;
                if (in_raw_symbol == sync_code_r) begin
                  kind_nxt = bsu_pkg::KIND_SYNC;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = in_raw_symbol + escape_code_r;
                  kind_nxt  = bsu_pkg::KIND_DATA;
                  sym_nxt   = in_raw_symbol + escape_code_r;
                end
              end else if (in_raw_symbol == escape_code_r) begin
                esc_nxt  = 1'b1;
                kind_nxt = bsu_pkg::KIND_ESCAPE;
              end else if (in_raw_symbol == sync_code_r) begin
                kind_nxt = bsu_pkg::KIND_SYNC;
              end else begin
                mem_we   = 1'b1;
                kind_nxt = bsu_pkg::KIND_DATA;
                sym_nxt  = in_raw_symbol;
              end
              // push: advance write pointer, drop oldest when full
              if (mem_we) begin
                next_nxt = push_next;
                if (push_next == oldest_r) begin
                  oldest_nxt = bsu_pkg::ring_next(oldest_r);
                end
              end
            end
            bsu_pkg::ACT_DRAIN: begin
              if (oldest_r == next_r) begin
                out_valid_nxt = 1'b1;
                kind_nxt      = bsu_pkg::KIND_EMPTY;
                sym_nxt       = '0;
                crc_out_nxt   = crc_r;
                last_nxt      = 1'b1;
              end else begin
                state_nxt = ST_READ;
              end
            end
            bsu_pkg::ACT_CLEAR: begin
              crc_nxt       = '0;
              out_valid_nxt = 1'b1;
              kind_nxt      = bsu_pkg::KIND_CLEARED;
              sym_nxt       = '0;
              crc_out_nxt   = '0;
              last_nxt      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // fetch oldest entry, pop it
        mem_re     = 1'b1;
        oldest_nxt = bsu_pkg::ring_next(oldest_r);
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = bsu_pkg::KIND_HISTORY;
          sym_nxt       = rd_data_r;
          crc_out_nxt   = crc_r;
          last_nxt      = (oldest_r == next_r);
          state_nxt     = (oldest_r == next_r) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      esc_r       <= 1'b0;
      crc_r       <= '0;
      oldest_r    <= '0;
      next_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      esc_r       <= esc_nxt;
      crc_r       <= crc_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
    end
    kind_r    <= kind_nxt;
    sym_r     <= sym_nxt;
    crc_out_r <= crc_out_nxt;
    last_r    <= last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_code_r   <= bsu_pkg::SYNC_CODE_RST;
      escape_code_r <= bsu_pkg::ESCAPE_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsu_pkg::CFG_SYNC_CODE:   sync_code_r   <= cfg_data;
        bsu_pkg::CFG_ESCAPE_CODE: escape_code_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // history RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[next_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= hist_mem[oldest_r];
    end
  end

  // a push always leaves the history non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (oldest_r != next_r))
    else $error("history empty after push");

  // a history read is only issued on a non-empty history
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (oldest_r != next_r))
    else $error("history read while empty");

  // a clear request yields a cleared result with zero crc
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == bsu_pkg::ACT_CLEAR) |=>
      (out_valid && out_kind == bsu_pkg::KIND_CLEARED && out_crc_now == 8'd0 && crc_r == 8'd0))
    else $error("clear request result mismatch");

endmodule
